[sv/hnrg_pkg.sv]
`default_nettype none
package hnrg_pkg;

    localparam logic [2:0] FN_ISSUE   = 3'd0;
    localparam logic [2:0] FN_READ    = 3'd1;
    localparam logic [2:0] FN_CONSUME = 3'd2;
    localparam logic [2:0] FN_DISCARD = 3'd3;
    localparam logic [2:0] FN_ASK     = 3'd4;

    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_INVALID = 3'd1;
    localparam logic [2:0] ST_FULL    = 3'd2;
    localparam logic [2:0] ST_NOMATCH = 3'd3;
    localparam logic [2:0] ST_COLL    = 3'd4;

    localparam logic [4:0] CFG_RESET  = 5'd16;

    typedef struct packed {
        logic start;   // latch request, clear scan accumulators
        logic step;    // advance slot scan
        logic commit;  // apply decision, load result register
    } t_cmd;

    typedef struct packed {
        logic scan_done;
    } t_stat;

endpackage
`default_nettype wire

[sv/hnrg_ctrl.sv]
`default_nettype none
module hnrg_ctrl (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                i_valid,
    output logic               o_ready,
    output logic               o_valid,
    input  wire                i_ready,
    input  hnrg_pkg::t_stat    i_stat,
    output hnrg_pkg::t_cmd     o_cmd
);
    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_SCAN   = 2'd1;
    localparam logic [1:0] S_DECIDE = 2'd2;

    logic [1:0] r_state, n_state;
    logic       r_ovalid, n_ovalid;

    always_comb begin
        n_state      = r_state;
        n_ovalid     = r_ovalid;
        o_cmd        = '0;
        o_ready      = (r_state == S_IDLE);
        if (r_ovalid && i_ready) n_ovalid = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.start = 1'b1;
                    n_state     = S_SCAN;
                end
            end
            S_SCAN: begin
                o_cmd.step = 1'b1;
                if (i_stat.scan_done) n_state = S_DECIDE;
            end
            S_DECIDE: begin
                if (!r_ovalid || i_ready) begin
                    o_cmd.commit = 1'b1;
                    n_ovalid     = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_ovalid <= n_ovalid;
        end
    end

    assign o_valid = r_ovalid;

    // result register never overwritten while still pending
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> o_valid)
        else $error("pending result dropped");
    a_one_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({o_cmd.start, o_cmd.step, o_cmd.commit}))
        else $error("overlapping commands");
    a_accept_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> !o_ready)
        else $error("second transaction accepted during scan");
endmodule
`default_nettype wire

[sv/hnrg_dp.sv]
`default_nettype none
module hnrg_dp #(
    parameter int CAPACITY      = 16,
    parameter int NONCE_OCTETS  = 16,
    parameter int PEER_TAG_BITS = 32
) (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                i_cfg_we,
    input  wire  [4:0]         i_cfg_data,
    input  wire  [2:0]         i_func,
    input  wire  [31:0]        i_peer_tag,
    input  wire  [63:0]        i_nonce_hi,
    input  wire  [63:0]        i_nonce_lo,
    input  wire  [62:0]        i_now_time,
    input  wire  [31:0]        i_ttl_seconds,
    input  hnrg_pkg::t_cmd     i_cmd,
    output hnrg_pkg::t_stat    o_stat,
    output logic [2:0]         o_status,
    output logic [63:0]        o_out_nonce_hi,
    output logic [63:0]        o_out_nonce_lo,
    output logic [4:0]         o_outstanding_count,
    output logic [4:0]         o_consumed_count
);
    localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int PW = (PEER_TAG_BITS < 32) ? PEER_TAG_BITS : 32;
    localparam int HI_BITS = (NONCE_OCTETS > 8) ? (NONCE_OCTETS - 8) * 8 : 0;
    localparam int LO_BITS = ((NONCE_OCTETS > 8) ? 8 : NONCE_OCTETS) * 8;
    localparam logic [63:0] HI_MASK = (HI_BITS == 0) ? 64'd0 :
        ((HI_BITS >= 64) ? {64{1'b1}} : ((64'd1 << HI_BITS) - 64'd1));
    localparam logic [63:0] LO_MASK = (LO_BITS >= 64) ? {64{1'b1}} :
        ((64'd1 << LO_BITS) - 64'd1);
    localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

    // request latch
    logic [2:0]    r_func;
    logic [PW-1:0] r_peer;
    logic          r_peer_nz;
    logic [63:0]   r_hi, r_lo;
    logic [62:0]   r_now;
    logic [31:0]   r_ttl;
    logic [4:0]    r_max_entries;

    // slot store
    logic [CAPACITY-1:0] r_valid, r_cons;
    logic [PW-1:0] mem_peer [CAPACITY];
    logic [63:0]   mem_hi   [CAPACITY];
    logic [63:0]   mem_lo   [CAPACITY];
    logic [62:0]   mem_exp  [CAPACITY];

    // scan pipeline
    logic [CW-1:0] r_cnt;
    logic          r_rd_vld;
    logic [IW-1:0] r_rd_idx;
    logic [PW-1:0] r_rd_peer;
    logic [63:0]   r_rd_hi, r_rd_lo;
    logic [62:0]   r_rd_exp;

    // scan accumulators
    logic          r_s_found, r_s_neq, r_d_found, r_coll, r_f_found;
    logic [IW-1:0] r_s_idx, r_d_idx, r_f_idx;
    logic [63:0]   r_s_hi, r_s_lo;
    logic [CW-1:0] r_oc, r_cc;

    // result register
    logic [2:0]    r_status;
    logic [63:0]   r_ohi, r_olo;
    logic [CW-1:0] r_ooc, r_occ;

    logic w_arg_ok, w_prune, w_v, w_c, w_exp, w_live, w_peq, w_neq;
    logic [63:0] w_sum;

    assign w_arg_ok = (r_func <= hnrg_pkg::FN_ASK) && r_peer_nz &&
                      ((r_func == hnrg_pkg::FN_DISCARD) || (r_now != 63'd0));
    assign w_prune  = w_arg_ok && (r_func != hnrg_pkg::FN_DISCARD);
    assign w_v      = r_valid[r_rd_idx];
    assign w_c      = r_cons[r_rd_idx];
    assign w_exp    = w_prune && w_v && (r_now > r_rd_exp);
    assign w_live   = w_v && !w_exp;
    assign w_peq    = (r_rd_peer == r_peer);
    assign w_neq    = (r_rd_hi == r_hi) && (r_rd_lo == r_lo);
    assign w_sum    = {1'b0, r_now} + {32'd0, r_ttl};

    assign o_stat.scan_done = (r_cnt == CAP_C) && !r_rd_vld;

    // decision
    logic [31:0]   w_lim, w_total;
    logic [2:0]    w_st;
    logic          w_wr, w_clr_s, w_clr_d, w_cons_s;
    logic [IW-1:0] w_wslot;
    logic [CW-1:0] w_oc, w_cc;

    always_comb begin
        w_lim = (r_max_entries == 5'd0) ? 32'd1 : 32'(r_max_entries);
        if (w_lim > 32'(CAPACITY)) w_lim = 32'(CAPACITY);
        w_total  = 32'(r_oc) + 32'(r_cc);
        w_st     = hnrg_pkg::ST_INVALID;
        w_wr     = 1'b0;
        w_clr_s  = 1'b0;
        w_clr_d  = 1'b0;
        w_cons_s = 1'b0;
        w_wslot  = r_s_found ? r_s_idx : r_f_idx;
        w_oc     = r_oc;
        w_cc     = r_cc;
        if (w_arg_ok) begin
            case (r_func)
                hnrg_pkg::FN_ISSUE: begin
                    if (r_ttl == 32'd0 || w_sum[63]) begin
                        w_st = hnrg_pkg::ST_INVALID;
                    end else if (!r_s_found && w_total >= w_lim) begin
                        w_st = hnrg_pkg::ST_FULL;
                    end else if (r_coll || r_d_found) begin
                        w_st = hnrg_pkg::ST_COLL;
                    end else if (!r_s_found && !r_f_found) begin
                        w_st = hnrg_pkg::ST_FULL;
                    end else begin
                        w_st = hnrg_pkg::ST_OK;
                        w_wr = 1'b1;
                        if (!r_s_found) w_oc = r_oc + CW'(1);
                    end
                end
                hnrg_pkg::FN_READ: begin
                    w_st = r_s_found ? hnrg_pkg::ST_OK : hnrg_pkg::ST_NOMATCH;
                end
                hnrg_pkg::FN_CONSUME, hnrg_pkg::FN_DISCARD: begin
                    if (!r_s_found || !r_s_neq) begin
                        w_st = hnrg_pkg::ST_NOMATCH;
                    end else if (r_func == hnrg_pkg::FN_DISCARD) begin
                        w_st    = hnrg_pkg::ST_OK;
                        w_clr_s = 1'b1;
                        w_oc    = r_oc - CW'(1);
                    end else if (w_total > w_lim) begin
                        w_st = hnrg_pkg::ST_FULL;
                    end else begin
                        w_st     = hnrg_pkg::ST_OK;
                        w_cons_s = 1'b1;
                        w_clr_d  = r_d_found;
                        w_oc     = r_oc - CW'(1);
                        w_cc     = r_d_found ? r_cc : r_cc + CW'(1);
                    end
                end
                hnrg_pkg::FN_ASK: begin
                    w_st = r_d_found ? hnrg_pkg::ST_OK : hnrg_pkg::ST_NOMATCH;
                end
                default: w_st = hnrg_pkg::ST_INVALID;
            endcase
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid       <= '0;
            r_cons        <= '0;
            r_cnt         <= CAP_C;
            r_rd_vld      <= 1'b0;
            r_max_entries <= hnrg_pkg::CFG_RESET;
        end else begin
            if (i_cfg_we) r_max_entries <= i_cfg_data;
            if (i_cmd.start) begin
                r_cnt    <= '0;
                r_rd_vld <= 1'b0;
            end else if (i_cmd.step && r_cnt != CAP_C) begin
                r_cnt    <= r_cnt + CW'(1);
                r_rd_vld <= 1'b1;
            end else begin
                r_rd_vld <= 1'b0;
            end
            if (r_rd_vld && w_exp) r_valid[r_rd_idx] <= 1'b0;
            if (i_cmd.commit) begin
                if (w_wr) begin
                    r_valid[w_wslot] <= 1'b1;
                    r_cons[w_wslot]  <= 1'b0;
                end
                if (w_clr_s) r_valid[r_s_idx] <= 1'b0;
                if (w_cons_s) r_cons[r_s_idx] <= 1'b1;
                if (w_clr_d) r_valid[r_d_idx] <= 1'b0;
            end
        end
    end

    // slot store read and write
    always_ff @(posedge i_clk) begin
        if (i_cmd.step && r_cnt != CAP_C) begin
            r_rd_idx  <= r_cnt[IW-1:0];
            r_rd_peer <= mem_peer[r_cnt[IW-1:0]];
            r_rd_hi   <= mem_hi[r_cnt[IW-1:0]];
            r_rd_lo   <= mem_lo[r_cnt[IW-1:0]];
            r_rd_exp  <= mem_exp[r_cnt[IW-1:0]];
        end
        if (i_cmd.commit && w_wr) begin
            mem_peer[w_wslot] <= r_peer;
            mem_hi[w_wslot]   <= r_hi;
            mem_lo[w_wslot]   <= r_lo;
            mem_exp[w_wslot]  <= w_sum[62:0];
        end
    end

    // request latch, accumulators, result
    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_func    <= i_func;
            r_peer    <= i_peer_tag[PW-1:0];
            r_peer_nz <= (i_peer_tag[PW-1:0] != '0);
            r_hi      <= i_nonce_hi & HI_MASK;
            r_lo      <= i_nonce_lo & LO_MASK;
            r_now     <= i_now_time;
            r_ttl     <= i_ttl_seconds;
            r_s_found <= 1'b0;
            r_d_found <= 1'b0;
            r_coll    <= 1'b0;
            r_f_found <= 1'b0;
            r_oc      <= '0;
            r_cc      <= '0;
        end else if (r_rd_vld) begin
            if (w_live && !w_c && w_peq && !r_s_found) begin
                r_s_found <= 1'b1;
                r_s_idx   <= r_rd_idx;
                r_s_neq   <= w_neq;
                r_s_hi    <= r_rd_hi;
                r_s_lo    <= r_rd_lo;
            end
            if (w_live && w_c && w_peq && w_neq && !r_d_found) begin
                r_d_found <= 1'b1;
                r_d_idx   <= r_rd_idx;
            end
            if (w_live && !w_c && w_neq) r_coll <= 1'b1;
            if (!w_live && !r_f_found) begin
                r_f_found <= 1'b1;
                r_f_idx   <= r_rd_idx;
            end
            if (w_live && !w_c) r_oc <= r_oc + CW'(1);
            if (w_live && w_c) r_cc <= r_cc + CW'(1);
        end
        if (i_cmd.commit) begin
            r_status <= w_st;
            r_ohi    <= (w_arg_ok && r_func == hnrg_pkg::FN_READ && r_s_found) ? r_s_hi : 64'd0;
            r_olo    <= (w_arg_ok && r_func == hnrg_pkg::FN_READ && r_s_found) ? r_s_lo : 64'd0;
            r_ooc    <= w_oc;
            r_occ    <= w_cc;
        end
    end

    logic [31:0] w_ooc32, w_occ32;
    assign w_ooc32 = 32'(r_ooc);
    assign w_occ32 = 32'(r_occ);

    assign o_status            = r_status;
    assign o_out_nonce_hi      = r_ohi;
    assign o_out_nonce_lo      = r_olo;
    assign o_outstanding_count = (w_ooc32 > 32'd31) ? 5'd31 : w_ooc32[4:0];
    assign o_consumed_count    = (w_occ32 > 32'd31) ? 5'd31 : w_occ32[4:0];

    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CAP_C)
        else $error("scan counter past capacity");
    a_start_clr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.start |=> (r_cnt == '0 && !r_rd_vld))
        else $error("scan not restarted");
    a_commit_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.commit |-> o_stat.scan_done)
        else $error("commit before scan finished");
endmodule
`default_nettype wire

[sv/handshake_nonce_replay_guard.sv]
`default_nettype none
// Channel   | Handshake            | Payload
// ----------+----------------------+---------------------------------------------
// request   | i_valid / o_ready    | i_func i_peer_tag i_nonce_hi/lo i_now_time
//           |                      | i_ttl_seconds
// result    | o_valid / i_ready    | o_status o_out_nonce_hi/lo o_outstanding_count
//           |                      | o_consumed_count
// config    | i_cfg_we             | i_cfg_data (max_entries)
//
// A transaction latches the request, walks the slot store through its single
// registered read port while pruning and matching (the walk ends once the last
// read has landed and the done flag is set), then decides and writes.
// The next request is taken the cycle after the decision is loaded; a pending
// result holds in its register while the next scan runs, and a new decision
// waits for it to be taken. Synchronous active-low reset empties the store
// (valid and consumed bits only) and sets max_entries to 16.
module handshake_nonce_replay_guard #(
    parameter int CAPACITY      = 16,
    parameter int NONCE_OCTETS  = 16,
    parameter int PEER_TAG_BITS = 32
) (
    input  wire          i_clk,
    input  wire          i_rst_n,
    input  wire          i_cfg_we,
    input  wire  [4:0]   i_cfg_data,
    input  wire          i_valid,
    output logic         o_ready,
    input  wire  [2:0]   i_func,
    input  wire  [31:0]  i_peer_tag,
    input  wire  [63:0]  i_nonce_hi,
    input  wire  [63:0]  i_nonce_lo,
    input  wire  [62:0]  i_now_time,
    input  wire  [31:0]  i_ttl_seconds,
    output logic         o_valid,
    input  wire          i_ready,
    output logic [2:0]   o_status,
    output logic [63:0]  o_out_nonce_hi,
    output logic [63:0]  o_out_nonce_lo,
    output logic [4:0]   o_outstanding_count,
    output logic [4:0]   o_consumed_count
);
    hnrg_pkg::t_cmd  w_cmd;
    hnrg_pkg::t_stat w_stat;

    // sequencer: idle -> scan -> decide
    hnrg_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .i_stat  (w_stat),
        .o_cmd   (w_cmd)
    );

    // slot store, scan accumulators, decision and result register
    hnrg_dp #(
        .CAPACITY      (CAPACITY),
        .NONCE_OCTETS  (NONCE_OCTETS),
        .PEER_TAG_BITS (PEER_TAG_BITS)
    ) u_dp (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cfg_we            (i_cfg_we),
        .i_cfg_data          (i_cfg_data),
        .i_func              (i_func),
        .i_peer_tag          (i_peer_tag),
        .i_nonce_hi          (i_nonce_hi),
        .i_nonce_lo          (i_nonce_lo),
        .i_now_time          (i_now_time),
        .i_ttl_seconds       (i_ttl_seconds),
        .i_cmd               (w_cmd),
        .o_stat              (w_stat),
        .o_status            (o_status),
        .o_out_nonce_hi      (o_out_nonce_hi),
        .o_out_nonce_lo      (o_out_nonce_lo),
        .o_outstanding_count (o_outstanding_count),
        .o_consumed_count    (o_consumed_count)
    );
endmodule
`default_nettype wire
